// ===== rtl/tae_pkg.sv =====
// shared constants and helpers for the three-address evaluator
package tae_pkg;

    localparam int NUM_VARS = 26;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(NUM_VARS);
    localparam int CNT_W    = $clog2(DATA_W);

    // field widths on the stream ports
    localparam int FLD_W     = 32;
    localparam int VAR_FLD_W = 5;
    localparam int OP_W      = 3;
    localparam int STAT_W    = 2;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 40;

    // operator codes
    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_STORED  = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_OP  = 2'd1;
    localparam logic [STAT_W-1:0] ST_DIV_ZERO = 2'd2;

    // clamp a raw index to the last variable
    function automatic logic [IDX_W-1:0] sat_idx(input logic [FLD_W-1:0] raw);
        if (raw >= FLD_W'(NUM_VARS)) begin
            return IDX_W'(NUM_VARS - 1);
        end
        return raw[IDX_W-1:0];
    endfunction

    // sign-extend a 32-bit immediate, then wrap to the data width
    function automatic logic [DATA_W-1:0] imm_to_data(input logic [FLD_W-1:0] v);
        logic [63:0] w;
        w = {{32{v[FLD_W-1]}}, v};
        return w[DATA_W-1:0];
    endfunction

    // wrap a stored value to the 32-bit result field
    function automatic logic [FLD_W-1:0] data_to_fld(input logic [DATA_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[FLD_W-1:0];
    endfunction

endpackage

// ===== rtl/three_address_evaluator_top.sv =====
// three-address evaluator: variable store with bit-serial add, sub, mul and div
// path from input beat to result beat: fetch, setup, DATA_W serial steps of the shared datapath
// and writeback for add, sub and mul, with a sign fix between the serial steps and writeback for div;
// a move, an invalid operator or a divide by zero goes from setup straight to writeback
// one beat in flight at a time: next input beat can be taken from the cycle after the result is queued
// aresetn (sync, active low) clears the fsm, the output valid flag and all variable valid bits
module three_address_evaluator_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // dest_var[4:0], op_code[7:5], src1_is_var[8], src1[40:9], src2_is_var[41],
    // src2[73:42], zero pad[79:74]
    input  logic [tae_pkg::S_TDATA_W-1:0] s_tdata,
    // kind[0]
    input  logic                          s_tuser,
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[1:0], out_var[6:2], out_value[38:7], zero pad[39]
    output logic [tae_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int DW = tae_pkg::DATA_W;
    localparam int IW = tae_pkg::IDX_W;
    localparam int CW = tae_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_SETUP,
        S_RUN,
        S_FIX,
        S_WB
    } state_t;

    // input beat unpacking
    logic [tae_pkg::VAR_FLD_W-1:0] in_dest;
    logic [tae_pkg::OP_W-1:0]      in_op;
    logic                          in_s1v;
    logic [tae_pkg::FLD_W-1:0]     in_src1;
    logic                          in_s2v;
    logic [tae_pkg::FLD_W-1:0]     in_src2;
    logic [IW-1:0]                 in_idx1;
    logic [IW-1:0]                 in_idx2;
    logic                          in_beat;

    assign in_dest = s_tdata[4:0];
    assign in_op   = s_tdata[7:5];
    assign in_s1v  = s_tdata[8];
    assign in_src1 = s_tdata[40:9];
    assign in_s2v  = s_tdata[41];
    assign in_src2 = s_tdata[73:42];
    assign in_idx1 = tae_pkg::sat_idx(in_src1);
    assign in_idx2 = tae_pkg::sat_idx(in_src2);

    // variable store; an entry never written reads as zero via its valid bit
    logic [DW-1:0]       mem [tae_pkg::NUM_VARS];
    logic [tae_pkg::NUM_VARS-1:0] vld_reg;
    logic [DW-1:0]       rd1_reg, rd2_reg;
    logic                rd1_vld_reg, rd2_vld_reg;

    // item registers
    state_t              state_reg;
    logic                kind_reg;
    logic [tae_pkg::OP_W-1:0] op_reg;
    logic [IW-1:0]       dest_reg;
    logic                s1v_reg, s2v_reg;
    logic [DW-1:0]       imm1_reg, imm2_reg;

    // serial datapath: a and b shift, res or rem collects
    logic [DW-1:0]       a_reg, b_reg, res_reg, rem_reg;
    logic                carry_reg;
    logic                neg_reg;
    logic [CW-1:0]       cnt_reg;
    logic [tae_pkg::STAT_W-1:0] status_reg;

    // output register
    logic                m_valid_reg;
    logic [tae_pkg::M_TDATA_W-1:0] m_data_reg;

    // one serial step of add, subtract and divide
    logic                sum_bit, b_bit, carry_next;
    logic [DW:0]         trial, diff;
    logic                q_bit;
    logic                last_step;
    logic                out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        // add and subtract: one bit per cycle, lsb first
        b_bit      = b_reg[0] ^ (op_reg == tae_pkg::OP_SUB);
        sum_bit    = a_reg[0] ^ b_bit ^ carry_reg;
        carry_next = (a_reg[0] & b_bit) | (a_reg[0] & carry_reg) | (b_bit & carry_reg);
        // restoring divide: one quotient bit per cycle, msb first
        trial      = {rem_reg, a_reg[DW-1]};
        diff       = trial - {1'b0, b_reg};
        q_bit      = !diff[DW];
        last_step  = (cnt_reg == CW'(DW - 1));
    end

    // store write and registered reads
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            rd1_reg <= mem[in_idx1];
            rd2_reg <= mem[in_idx2];
        end
        if (state_reg == S_WB && out_free && status_reg == tae_pkg::ST_STORED) begin
            mem[dest_reg] <= res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            rd1_vld_reg <= 1'b0;
            rd2_vld_reg <= 1'b0;
        end else begin
            if (in_beat) begin
                rd1_vld_reg <= vld_reg[in_idx1];
                rd2_vld_reg <= vld_reg[in_idx2];
            end
            if (state_reg == S_WB && out_free && status_reg == tae_pkg::ST_STORED) begin
                vld_reg[dest_reg] <= 1'b1;
            end
        end
    end

    // sequencer and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // result beat is queued from writeback, dropped once taken
            if (state_reg == S_WB && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        kind_reg  <= s_tuser;
                        op_reg    <= in_op;
                        dest_reg  <= tae_pkg::sat_idx(tae_pkg::FLD_W'(in_dest));
                        s1v_reg   <= in_s1v;
                        s2v_reg   <= in_s2v;
                        imm1_reg  <= tae_pkg::imm_to_data(in_src1);
                        imm2_reg  <= tae_pkg::imm_to_data(in_src2);
                        state_reg <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    a_reg     <= s1v_reg ? (rd1_vld_reg ? rd1_reg : '0) : imm1_reg;
                    b_reg     <= s2v_reg ? (rd2_vld_reg ? rd2_reg : '0) : imm2_reg;
                    state_reg <= S_SETUP;
                end
                S_SETUP: begin
                    cnt_reg    <= '0;
                    rem_reg    <= '0;
                    carry_reg  <= (op_reg == tae_pkg::OP_SUB);
                    if (kind_reg) begin
                        // move of the first operand
                        res_reg    <= a_reg;
                        status_reg <= tae_pkg::ST_STORED;
                        state_reg  <= S_WB;
                    end else begin
                        res_reg <= '0;
                        case (op_reg)
                            tae_pkg::OP_ADD, tae_pkg::OP_SUB, tae_pkg::OP_MUL: begin
                                status_reg <= tae_pkg::ST_STORED;
                                state_reg  <= S_RUN;
                            end
                            tae_pkg::OP_DIV: begin
                                if (b_reg == '0) begin
                                    status_reg <= tae_pkg::ST_DIV_ZERO;
                                    state_reg  <= S_WB;
                                end else begin
                                    // divide magnitudes, fix the sign at the end
                                    status_reg <= tae_pkg::ST_STORED;
                                    a_reg      <= a_reg[DW-1] ? (~a_reg + 1'b1) : a_reg;
                                    b_reg      <= b_reg[DW-1] ? (~b_reg + 1'b1) : b_reg;
                                    neg_reg    <= a_reg[DW-1] ^ b_reg[DW-1];
                                    state_reg  <= S_RUN;
                                end
                            end
                            default: begin
                                status_reg <= tae_pkg::ST_BAD_OP;
                                state_reg  <= S_WB;
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    case (op_reg)
                        tae_pkg::OP_MUL: begin
                            // shift-add, low DW bits of the product
                            res_reg <= res_reg + (b_reg[0] ? a_reg : '0);
                            a_reg   <= {a_reg[DW-2:0], 1'b0};
                            b_reg   <= {1'b0, b_reg[DW-1:1]};
                        end
                        tae_pkg::OP_DIV: begin
                            // quotient bits shift into a as dividend bits leave
                            rem_reg <= q_bit ? diff[DW-1:0] : trial[DW-1:0];
                            a_reg   <= {a_reg[DW-2:0], q_bit};
                        end
                        default: begin
                            res_reg   <= {sum_bit, res_reg[DW-1:1]};
                            carry_reg <= carry_next;
                            a_reg     <= {1'b0, a_reg[DW-1:1]};
                            b_reg     <= {1'b0, b_reg[DW-1:1]};
                        end
                    endcase
                    if (last_step) begin
                        state_reg <= (op_reg == tae_pkg::OP_DIV) ? S_FIX : S_WB;
                    end
                end
                S_FIX: begin
                    // most negative / -1 comes out as the most negative value
                    res_reg   <= neg_reg ? (~a_reg + 1'b1) : a_reg;
                    state_reg <= S_WB;
                end
                S_WB: begin
                    if (out_free) begin
                        m_data_reg  <= {1'b0,
                                        (status_reg == tae_pkg::ST_STORED) ?
                                            tae_pkg::data_to_fld(res_reg) : '0,
                                        tae_pkg::VAR_FLD_W'(dest_reg),
                                        status_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== tb/sv/tae_result_checker.sv =====
// checker for the three-address evaluator: predicts each result beat and compares it
module tae_result_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // dest_var, op_code, src1_is_var, src1, src2_is_var, src2, zero pad
    input  logic [tae_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic                          s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // status, out_var, out_value, zero pad
    input  logic [tae_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            fail_count,
    output int                            results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tae_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [VAR_FLD_W-1:0] var_idx;
        logic [FLD_W-1:0]     value;
    } assign_result_t;

    assign_result_t    expected_results[$];
    logic [DATA_W-1:0] var_store [NUM_VARS];
    int                mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("tb: %s mismatch at %0t: got %0h, expected %0h", what, $time, got, want);
        mismatches++;
    endtask

    // indexes at or above the store size land on the last variable
    function automatic int clamp_index(input logic [31:0] raw);
        if (raw >= 32'(NUM_VARS)) begin
            return NUM_VARS - 1;
        end
        return int'(raw);
    endfunction

    function automatic logic [DATA_W-1:0] operand_value(input logic is_var,
                                                        input logic [31:0] raw);
        if (is_var) begin
            return var_store[clamp_index(raw)];
        end
        return DATA_W'(raw);
    endfunction

    // runs one assignment against the shadow store and returns its result beat
    function automatic assign_result_t execute_assignment(input logic is_move,
                                                          input logic [S_TDATA_W-1:0] cmd);
        int                  dest;
        logic [OP_W-1:0]     op;
        logic [DATA_W-1:0]   lhs;
        logic [DATA_W-1:0]   rhs;
        logic [DATA_W-1:0]   res;
        logic signed [63:0]  dividend;
        logic signed [63:0]  divisor;
        logic signed [63:0]  quotient;
        assign_result_t      r;
        dest     = clamp_index(32'(cmd[4:0]));
        op       = cmd[7:5];
        lhs      = operand_value(cmd[8], cmd[40:9]);
        rhs      = operand_value(cmd[41], cmd[73:42]);
        res      = '0;
        r.status = ST_STORED;
        if (is_move) begin
            res = lhs;
        end else begin
            case (op)
                OP_ADD: res = lhs + rhs;
                OP_SUB: res = lhs - rhs;
                OP_MUL: res = lhs * rhs;
                OP_DIV: begin
                    if (rhs == '0) begin
                        r.status = ST_DIV_ZERO;
                    end else begin
                        // 64-bit signed divide truncates toward zero, min / -1 wraps back
                        dividend = {{32{lhs[DATA_W-1]}}, lhs};
                        divisor  = {{32{rhs[DATA_W-1]}}, rhs};
                        quotient = dividend / divisor;
                        res      = quotient[DATA_W-1:0];
                    end
                end
                default: r.status = ST_BAD_OP;
            endcase
        end
        if (r.status == ST_STORED) begin
            var_store[dest] = res;
        end else begin
            res = '0;
        end
        r.var_idx = VAR_FLD_W'(dest);
        r.value   = FLD_W'(res);
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        assign_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_VARS; i++) begin
                var_store[i] = '0;
            end
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result beat", m_tdata[31:0], '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[1:0] !== want.status) begin
                        report_mismatch("status", 32'(m_tdata[1:0]), 32'(want.status));
                    end
                    if (m_tdata[6:2] !== want.var_idx) begin
                        report_mismatch("out_var", 32'(m_tdata[6:2]), 32'(want.var_idx));
                    end
                    if (m_tdata[38:7] !== want.value) begin
                        report_mismatch("out_value", m_tdata[38:7], want.value);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(execute_assignment(s_tuser, s_tdata));
            end
        end
        results_pending <= expected_results.size();
    end

endmodule

// ===== tb/sv/three_address_evaluator_top_tb.sv =====
// testbench top for the three-address evaluator: clock, reset, stimulus and verdict
module three_address_evaluator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tae_pkg::*;

    // kind carried on s_tuser
    localparam logic KIND_BINARY = 1'b0;
    localparam logic KIND_MOVE   = 1'b1;

    // operator codes the block rejects
    localparam logic [OP_W-1:0] OP_INVALID_FIRST = 3'd4;
    localparam logic [OP_W-1:0] OP_INVALID_LAST  = 3'd7;

    // corner values of a signed 32-bit operand
    localparam logic [31:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_NEG1 = 32'hFFFF_FFFF;

    localparam int RANDOM_ITEMS = 1950;
    localparam int DRAIN_EVERY  = 400;
    // longest beat-to-result path is a divide, plus some slack
    localparam int SETTLE_CYCLES = 60;
    // receiver hold-off long enough to back the input side up
    localparam int HOLDOFF_CYCLES = 600;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    // dest_var[4:0], op_code[7:5], src1_is_var[8], src1[40:9], src2_is_var[41],
    // src2[73:42], zero pad[79:74]
    logic [S_TDATA_W-1:0]   s_tdata;
    // kind[0]
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    // status[1:0], out_var[6:2], out_value[38:7], zero pad[39]
    logic [M_TDATA_W-1:0]   m_tdata;

    int fail_count;
    int results_pending;

    // beats left in the current sender burst
    int burst_left = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    three_address_evaluator_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    tae_result_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    // offer one instruction beat and hold it until the block takes it;
    // a new burst may start with an idle gap, and back-to-back beats keep
    // tvalid high across the handshake edge
    task automatic send_item(input logic kind, input logic [4:0] dest, input logic [2:0] op,
                             input logic s1_var, input logic [31:0] s1,
                             input logic s2_var, input logic [31:0] s2);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 4) == 0) begin
                // long unbroken stretch, no idling
                gap        = 0;
                burst_left = $urandom_range(20, 60);
            end else begin
                // gaps up to past the divide latency so idling hits every step
                gap        = $urandom_range(1, 45);
                burst_left = $urandom_range(1, 8);
            end
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_TDATA_W'({s2, s2_var, s1, s1_var, op, dest});
        do begin
            @(posedge aclk);
        end while (!s_tready);
        burst_left--;
    endtask

    // sender goes quiet until every predicted result beat has come back
    task automatic wait_drained();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        // let the checker's count catch up with the last accepted beat before polling it
        @(posedge aclk);
        while (results_pending != 0) begin
            @(posedge aclk);
        end
    endtask

    // {is_var, value}: in-range variable reads most often, plus small, corner,
    // out-of-range and fully random operands
    function automatic logic [32:0] random_operand();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 42) begin
            return {1'b1, 32'($urandom_range(0, NUM_VARS - 1))};
        end
        if (sel < 45) begin
            return {1'b1, 32'($urandom_range(NUM_VARS, 40))};
        end
        if (sel < 48) begin
            return {1'b1, 32'($urandom())};
        end
        if (sel < 68) begin
            return {1'b0, 32'($urandom_range(0, 200)) - 32'd100};
        end
        if (sel < 84) begin
            case ($urandom_range(0, 4))
                0:       return {1'b0, 32'd0};
                1:       return {1'b0, 32'd1};
                2:       return {1'b0, VAL_NEG1};
                3:       return {1'b0, VAL_MIN};
                default: return {1'b0, VAL_MAX};
            endcase
        end
        return {1'b0, 32'($urandom())};
    endfunction

    // receiver: switches its stall pattern over random spans and now
    // and then holds off for a long stretch so the block backs up
    initial begin : receiver
        int span;
        int pattern;
        int stall_left;
        int cycles;
        int next_holdoff;
        stall_left   = 0;
        cycles       = 0;
        next_holdoff = 4000;
        forever begin
            pattern = $urandom_range(0, 3);
            span    = $urandom_range(50, 300);
            for (int i = 0; i < span; i++) begin
                case (pattern)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ((i % 7) >= 3);
                    default: begin
                        if (stall_left > 0) begin
                            m_tready <= 1'b0;
                            stall_left--;
                        end else begin
                            m_tready <= 1'b1;
                            if ($urandom_range(0, 9) == 0) begin
                                stall_left = $urandom_range(5, 30);
                            end
                        end
                    end
                endcase
                @(posedge aclk);
            end
            cycles += span;
            if (cycles >= next_holdoff) begin
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
                cycles       += HOLDOFF_CYCLES;
                next_holdoff += 50000;
            end
        end
    end

    initial begin : stimulus
        logic              kind;
        logic [4:0]        dest;
        logic [OP_W-1:0]   op;
        logic [32:0]       opnd_a;
        logic [32:0]       opnd_b;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= KIND_BINARY;
        s_tdata  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // moves of the corner values; op and src2 must be ignored on a move
        send_item(KIND_MOVE,   5'd0,  OP_INVALID_LAST, 1'b0, VAL_MAX, 1'b1, 32'd3);
        send_item(KIND_MOVE,   5'd1,  OP_DIV,          1'b0, VAL_MIN, 1'b0, 32'd0);
        send_item(KIND_MOVE,   5'd2,  OP_ADD,          1'b0, VAL_NEG1, 1'b0, VAL_MAX);
        // add and subtract wrap at 32 bits
        send_item(KIND_BINARY, 5'd3,  OP_ADD, 1'b1, 32'd0, 1'b0, 32'd1);
        send_item(KIND_BINARY, 5'd4,  OP_SUB, 1'b1, 32'd1, 1'b0, 32'd1);
        // multiply keeps the low word
        send_item(KIND_BINARY, 5'd5,  OP_MUL, 1'b1, 32'd0, 1'b1, 32'd0);
        send_item(KIND_BINARY, 5'd13, OP_MUL, 1'b0, VAL_MIN, 1'b0, VAL_NEG1);
        // min / -1 wraps to min, other divides truncate toward zero
        send_item(KIND_BINARY, 5'd6,  OP_DIV, 1'b1, 32'd1, 1'b1, 32'd2);
        send_item(KIND_BINARY, 5'd7,  OP_DIV, 1'b0, -32'sd7, 1'b0, 32'd2);
        send_item(KIND_BINARY, 5'd8,  OP_DIV, 1'b0, 32'd7, 1'b0, -32'sd2);
        // divide by zero, as an immediate and through a variable still at zero
        send_item(KIND_BINARY, 5'd9,  OP_DIV, 1'b0, 32'd5, 1'b0, 32'd0);
        send_item(KIND_BINARY, 5'd10, OP_DIV, 1'b1, 32'd0, 1'b1, 32'd20);
        // every rejected operator code
        for (int c = int'(OP_INVALID_FIRST); c <= int'(OP_INVALID_LAST); c++) begin
            send_item(KIND_BINARY, 5'd11, OP_W'(c), 1'b0, 32'd9, 1'b0, 32'd9);
        end
        // destination past the last variable lands on the last one
        send_item(KIND_MOVE,   5'd31, OP_ADD, 1'b0, 32'h5A5A_5A5A, 1'b0, 32'd0);
        send_item(KIND_BINARY, 5'd26, OP_ADD, 1'b1, 32'd25, 1'b0, 32'd1);
        // source variable indexes past the end, including negative-looking ones
        send_item(KIND_MOVE,   5'd12, OP_ADD, 1'b1, VAL_NEG1, 1'b0, 32'd0);
        send_item(KIND_BINARY, 5'd14, OP_SUB, 1'b1, VAL_MIN, 1'b1, 32'd26);
        send_item(KIND_BINARY, 5'd15, OP_DIV, 1'b1, 32'd25, 1'b1, 32'd200);
        send_item(KIND_BINARY, 5'd0,  OP_ADD, 1'b0, 32'd0, 1'b0, 32'd0);
        wait_drained();

        // random instructions, mostly valid assignments over the live store
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            kind   = ($urandom_range(0, 4) == 0) ? KIND_MOVE : KIND_BINARY;
            dest   = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(NUM_VARS, 31))
                                                 : 5'($urandom_range(0, NUM_VARS - 1));
            op     = ($urandom_range(0, 7) == 0)
                     ? OP_W'($urandom_range(int'(OP_INVALID_FIRST), int'(OP_INVALID_LAST)))
                     : OP_W'($urandom_range(int'(OP_ADD), int'(OP_DIV)));
            opnd_a = random_operand();
            opnd_b = random_operand();
            send_item(kind, dest, op, opnd_a[32], opnd_a[31:0], opnd_b[32], opnd_b[31:0]);
            // now and then the sender waits for the result side to empty
            if ((n % DRAIN_EVERY) == DRAIN_EVERY - 1) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && results_pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin : watchdog
        #10ms;
        $display("tb: failure");
        $finish;
    end

endmodule
